[src/jmao_pkg.sv]
package jmao_pkg;

  localparam int WINDOW_DEPTH = 8;
  localparam int SAMPLE_BITS  = 16;

  localparam int AXES      = 3;
  localparam int LANES     = 2 * AXES;
  localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
  localparam int CNT_BITS  = $clog2(WINDOW_DEPTH + 1);
  localparam int SLOT_BITS = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int REL_BITS  = SAMPLE_BITS + 1;
  localparam int STEP_BITS = $clog2(SUM_BITS);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;
  typedef logic signed [REL_BITS-1:0]    rel_t;
  typedef logic [CNT_BITS-1:0]           count_t;
  typedef logic [SLOT_BITS-1:0]          slot_t;

  // Sequencer to lane controls
  typedef struct packed {
    logic   capture;
    logic   full;
    slot_t  slot;
    logic   load;
    logic   step;
    count_t count;
  } lane_ctl_t;

endpackage

[src/jmao_in_if.sv]
interface jmao_in_if;
  import jmao_pkg::*;

  logic    valid;
  logic    ready;
  sample_t hand_x;
  sample_t hand_y;
  sample_t hand_z;
  sample_t spine_x;
  sample_t spine_y;
  sample_t spine_z;

  modport source (
    output valid, hand_x, hand_y, hand_z, spine_x, spine_y, spine_z,
    input  ready
  );

  modport sink (
    input  valid, hand_x, hand_y, hand_z, spine_x, spine_y, spine_z,
    output ready
  );
endinterface

[src/jmao_out_if.sv]
interface jmao_out_if;
  import jmao_pkg::*;

  logic   valid;
  logic   ready;
  rel_t   rel_x;
  rel_t   rel_y;
  rel_t   rel_z;
  count_t samples_in_window;

  modport source (
    output valid, rel_x, rel_y, rel_z, samples_in_window,
    input  ready
  );

  modport sink (
    input  valid, rel_x, rel_y, rel_z, samples_in_window,
    output ready
  );
endinterface

[src/joint_moving_average_offset_core.sv]
// Moving-average hand offset: each transaction carries hand and spine-base
// positions (three axes, signed Q3.12) and yields one result, the hand
// average minus the spine average per axis over the last WINDOW_DEPTH
// transactions (fewer until the window fills), each average truncated
// toward zero, plus the count of samples averaged. Six lanes, one per
// coordinate, each keep a sample ring, a running sum and a bit-serial
// divider by the fill count; a transaction occupies the block, which takes
// no other, until its one-bit-per-cycle divide is done. A finished result
// sits in an output register, so the next transaction is taken while it
// waits downstream; if that register is still full when the next divide
// ends, the block holds.
module joint_moving_average_offset_core (
  input  logic      clk,
  input  logic      rst,
  jmao_in_if.sink   item_in,
  jmao_out_if.source result_out
);
  import jmao_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_OUT
  } state_t;

  state_t               state;
  count_t               fill;
  slot_t                slot;
  logic [STEP_BITS-1:0] step;
  logic                 accept;
  logic                 full;
  logic                 free;
  logic                 out_load;
  lane_ctl_t            ctl;
  sample_t              lane_sample [LANES];
  sample_t              lane_avg    [LANES];

  assign item_in.ready = (state == S_IDLE) && !rst;
  assign accept        = item_in.valid && item_in.ready;
  assign full          = (fill == CNT_BITS'(WINDOW_DEPTH));
  assign out_load      = (state == S_OUT) && free;

  always_comb begin
    ctl.capture = accept;
    ctl.full    = full;
    ctl.slot    = slot;
    ctl.load    = (state == S_LOAD);
    ctl.step    = (state == S_DIV);
    ctl.count   = fill;
  end

  assign lane_sample[0] = item_in.hand_x;
  assign lane_sample[1] = item_in.hand_y;
  assign lane_sample[2] = item_in.hand_z;
  assign lane_sample[3] = item_in.spine_x;
  assign lane_sample[4] = item_in.spine_y;
  assign lane_sample[5] = item_in.spine_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      slot  <= '0;
      step  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (!full) begin
              fill <= fill + 1'b1;
            end
            slot  <= (slot == SLOT_BITS'(WINDOW_DEPTH - 1)) ? '0 : slot + 1'b1;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (step == STEP_BITS'(SUM_BITS - 1)) begin
            state <= S_OUT;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_OUT: begin
          // Hold until the output register can take the result
          if (free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    jmao_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .sample (lane_sample[i]),
      .avg    (lane_avg[i])
    );
  end

  jmao_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .load       (out_load),
    .count      (fill),
    .avg        (lane_avg),
    .free       (free),
    .result_out (result_out)
  );
endmodule

[src/jmao_lane.sv]
module jmao_lane (
  input  logic                clk,
  input  logic                rst,
  input  jmao_pkg::lane_ctl_t ctl,
  input  jmao_pkg::sample_t   sample,
  output jmao_pkg::sample_t   avg
);
  import jmao_pkg::*;

  sample_t               ring [WINDOW_DEPTH];
  sum_t                  sum;
  sum_t                  sum_next;
  logic [SUM_BITS-1:0]   mag;
  logic [SUM_BITS-1:0]   quo;
  logic [SUM_BITS-1:0]   quo_signed;
  count_t                rem;
  logic [CNT_BITS:0]     rem_sh;
  logic [CNT_BITS:0]     rem_diff;
  logic                  take;
  logic                  neg;

  always_comb begin
    // Retire the oldest sample once the window is full
    sum_next = sum + sum_t'(sample) - (ctl.full ? sum_t'(ring[ctl.slot]) : sum_t'(0));
    mag      = sum[SUM_BITS-1] ? (~unsigned'(sum) + 1'b1) : unsigned'(sum);
    rem_sh   = {rem, quo[SUM_BITS-1]};
    rem_diff = rem_sh - {1'b0, ctl.count};
    take     = rem_sh >= {1'b0, ctl.count};
    quo_signed = neg ? (~quo + 1'b1) : quo;
    avg      = sample_t'(quo_signed[SAMPLE_BITS-1:0]);
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      ring[ctl.slot] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctl.capture) begin
      sum <= sum_next;
    end
  end

  // Restoring divide of |sum| by the fill count, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      quo <= mag;
      neg <= sum[SUM_BITS-1];
      rem <= '0;
    end else if (ctl.step) begin
      quo <= {quo[SUM_BITS-2:0], take};
      rem <= take ? rem_diff[CNT_BITS-1:0] : rem_sh[CNT_BITS-1:0];
    end
  end
endmodule

[src/jmao_merge.sv]
module jmao_merge (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  jmao_pkg::count_t  count,
  input  jmao_pkg::sample_t avg [jmao_pkg::LANES],
  output logic              free,
  jmao_out_if.source        result_out
);
  import jmao_pkg::*;

  assign free = !result_out.valid || result_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (load) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  // Hand lanes first, spine lanes after
  always_ff @(posedge clk) begin
    if (load) begin
      result_out.rel_x             <= rel_t'(avg[0]) - rel_t'(avg[AXES]);
      result_out.rel_y             <= rel_t'(avg[1]) - rel_t'(avg[AXES + 1]);
      result_out.rel_z             <= rel_t'(avg[2]) - rel_t'(avg[AXES + 2]);
      result_out.samples_in_window <= count;
    end
  end
endmodule

[tb/tb_joint_moving_average_offset_core.sv]
module tb_joint_moving_average_offset_core;
  import jmao_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 3 * (SUM_BITS + 3);
  localparam int RX_HOLD_CYCLES = 400;

  typedef struct packed {
    rel_t   rel_x;
    rel_t   rel_y;
    rel_t   rel_z;
    count_t samples;
  } offset_t;

  logic clk = 1'b0;
  logic rst;

  jmao_in_if  item_in ();
  jmao_out_if result_out ();

  joint_moving_average_offset_core dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_in),
    .result_out (result_out)
  );

  always #5 clk = ~clk;

  // Predictor state: sample windows, running sums, fill level
  sample_t hand_win  [WINDOW_DEPTH][AXES];
  sample_t spine_win [WINDOW_DEPTH][AXES];
  longint  lane_sum  [LANES];
  int      fill;
  int      next_slot;

  offset_t pending_offsets[$];
  int      error_count = 0;
  int      cycle_count = 0;
  bit      steady = 1'b0;
  bit      hold_trigger = 1'b0;
  bit      hold_seen = 1'b0;
  int      rx_hold_len = 0;

  function automatic void predict_offset(input sample_t h [AXES], input sample_t s [AXES]);
    longint  hand_avg;
    longint  spine_avg;
    rel_t    rel [AXES];
    offset_t o;
    bit      full;
    full = (fill >= WINDOW_DEPTH);
    for (int a = 0; a < AXES; a++) begin
      // drop the oldest sample once the window is full
      if (full) begin
        lane_sum[a]        -= longint'(hand_win[next_slot][a]);
        lane_sum[AXES + a] -= longint'(spine_win[next_slot][a]);
      end
      hand_win[next_slot][a]  = h[a];
      spine_win[next_slot][a] = s[a];
      lane_sum[a]        += longint'(h[a]);
      lane_sum[AXES + a] += longint'(s[a]);
    end
    if (!full) fill++;
    next_slot = (next_slot + 1) % WINDOW_DEPTH;
    for (int a = 0; a < AXES; a++) begin
      // signed divide truncates toward zero
      hand_avg  = lane_sum[a] / longint'(fill);
      spine_avg = lane_sum[AXES + a] / longint'(fill);
      rel[a] = rel_t'(hand_avg - spine_avg);
    end
    o.rel_x   = rel[0];
    o.rel_y   = rel[1];
    o.rel_z   = rel[2];
    o.samples = count_t'(fill);
    pending_offsets = {pending_offsets, o};
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  task automatic send_positions(input sample_t hx, hy, hz, sx, sy, sz);
    int      gap;
    sample_t h [AXES];
    sample_t s [AXES];
    gap = 0;
    if (!steady)
      while ($urandom_range(99) < 33) gap++;
    if (gap > 0) begin
      item_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_in.valid   <= 1'b1;
    item_in.hand_x  <= hx;
    item_in.hand_y  <= hy;
    item_in.hand_z  <= hz;
    item_in.spine_x <= sx;
    item_in.spine_y <= sy;
    item_in.spine_z <= sz;
    do @(posedge clk); while (!item_in.ready);
    h = '{hx, hy, hz};
    s = '{sx, sy, sz};
    predict_offset(h, s);
  endtask

  task automatic wait_for_results();
    item_in.valid <= 1'b0;
    while (pending_offsets.size() != 0) @(posedge clk);
  endtask

  function automatic sample_t pick_sample(input int mode);
    case (mode)
      0: return sample_t'($urandom);
      1: return sample_t'(int'($urandom_range(40)) - 20);
      default: begin
        case ($urandom_range(3))
          0: return sample_t'(32767);
          1: return sample_t'(-32768);
          2: return sample_t'(0);
          default: return sample_t'(-1);
        endcase
      end
    endcase
  endfunction

  task automatic send_random_item();
    int r;
    int mode;
    r = $urandom_range(99);
    mode = (r < 60) ? 0 : (r < 85) ? 1 : 2;
    send_positions(pick_sample(mode), pick_sample(mode), pick_sample(mode),
                   pick_sample(mode), pick_sample(mode), pick_sample(mode));
  endtask

  // Window filling from empty to full; small negative sums check truncation
  task automatic test_fill_and_wrap();
    for (int i = 0; i < 8; i++)
      send_positions(sample_t'(-(i % 3)), sample_t'(3 * i - 10), sample_t'(-32768 + i),
                     sample_t'(i % 2), sample_t'(-5 * i), sample_t'(32767 - i));
  endtask

  // Extreme inputs held across a full window give the widest offsets
  task automatic test_extremes();
    for (int i = 0; i < 8; i++)
      send_positions(sample_t'(32767), sample_t'(32767), sample_t'(-32768),
                     sample_t'(-32768), sample_t'(-32768), sample_t'(32767));
    for (int i = 0; i < 8; i++)
      send_positions(sample_t'(-32768), sample_t'(-32768), sample_t'(32767),
                     sample_t'(32767), sample_t'(32767), sample_t'(-32768));
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    steady = 1'b1;
    hold_trigger = ~hold_trigger;
    for (int i = 0; i < 30; i++) send_random_item();
    steady = 1'b0;
  endtask

  task automatic test_random_stream();
    for (int i = 0; i < 650; i++) begin
      steady = (i >= 100 && i < 250);
      if (i == 400) wait_for_results();
      send_random_item();
    end
    steady = 1'b0;
  endtask

  // Receiver
  always @(posedge clk) begin
    if (rst) begin
      result_out.ready <= 1'b0;
    end else if (hold_trigger != hold_seen) begin
      hold_seen        <= hold_trigger;
      rx_hold_len      <= RX_HOLD_CYCLES - 1;
      result_out.ready <= 1'b0;
    end else if (rx_hold_len > 0) begin
      result_out.ready <= 1'b0;
      rx_hold_len <= rx_hold_len - 1;
    end else if (steady) begin
      result_out.ready <= 1'b1;
    end else begin
      result_out.ready <= ($urandom_range(99) >= 33);
    end
  end

  // Result checker
  always @(posedge clk) begin
    offset_t want;
    if (!rst && result_out.valid && result_out.ready) begin
      if (pending_offsets.size() == 0) begin
        report_mismatch("unexpected transaction, rel_x", result_out.rel_x, 0);
      end else begin
        want = pending_offsets[0];
        pending_offsets.delete(0);
        if (result_out.rel_x !== want.rel_x)
          report_mismatch("rel_x", result_out.rel_x, want.rel_x);
        if (result_out.rel_y !== want.rel_y)
          report_mismatch("rel_y", result_out.rel_y, want.rel_y);
        if (result_out.rel_z !== want.rel_z)
          report_mismatch("rel_z", result_out.rel_z, want.rel_z);
        if (result_out.samples_in_window !== want.samples)
          report_mismatch("samples_in_window", result_out.samples_in_window, want.samples);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    item_in.valid   <= 1'b0;
    item_in.hand_x  <= '0;
    item_in.hand_y  <= '0;
    item_in.hand_z  <= '0;
    item_in.spine_x <= '0;
    item_in.spine_y <= '0;
    item_in.spine_z <= '0;
    for (int w = 0; w < WINDOW_DEPTH; w++)
      for (int a = 0; a < AXES; a++) begin
        hand_win[w][a]  = '0;
        spine_win[w][a] = '0;
      end
    for (int l = 0; l < LANES; l++) lane_sum[l] = 0;
    fill = 0;
    next_slot = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_fill_and_wrap();
    test_extremes();
    test_backpressure();
    test_random_stream();

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

[sim.f]
src/jmao_pkg.sv
src/jmao_in_if.sv
src/jmao_out_if.sv
src/jmao_lane.sv
src/jmao_merge.sv
src/joint_moving_average_offset_core.sv
tb/tb_joint_moving_average_offset_core.sv
